[rtl/core/jet_pkg.sv]
// Shared types, constants and helpers of the Julia escape-time core.
`timescale 1ns / 1ps

package jet_pkg;

	// Q6.26 number format
	localparam int FRAC_BITS = 26;
	localparam int WORD_W    = 32;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int SUM_W     = 40;

	// Frame geometry
	localparam int FRAME_WIDTH = 1024;

	// Field widths
	localparam int COORD_W = 10;
	localparam int COUNT_W = 16;
	localparam int INDEX_W = 20;
	localparam int CFG_IDX_W = 3;

	// Mapping and Julia constants, Q6.26 rounded to nearest
	localparam logic signed [WORD_W-1:0] K_STEP = 32'sd348966;
	localparam logic signed [WORD_W-1:0] K_XOFS = 32'sd178308252;
	localparam logic signed [WORD_W-1:0] K_YOFS = 32'sd134217728;
	localparam logic signed [WORD_W-1:0] K_CRE  = -32'sd48781433;
	localparam logic signed [WORD_W-1:0] K_CIM  = 32'sd12676864;

	// Escape radius squared, 4.0 in Q12.52
	localparam logic [PROD_W:0] ESCAPE_LIMIT = 65'd4 << 52;

	// Reset values of the configuration registers
	localparam logic [COUNT_W-1:0]  MAX_ITER_RST = 16'd64;
	localparam logic [WORD_W-2:0]   ZOOM_RST     = 31'd67108864;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_col;
		logic [COORD_W-1:0] pixel_row;
	} pixel_t;

	typedef struct packed {
		logic [COUNT_W-1:0] iteration_count;
		logic               inside_set;
		logic [INDEX_W-1:0] pixel_index;
	} result_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_ITER  = 3'd0,
		CFG_C_RE_OFF  = 3'd1,
		CFG_C_IM_OFF  = 3'd2,
		CFG_ZOOM      = 3'd3,
		CFG_CENTER_RE = 3'd4,
		CFG_CENTER_IM = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP0,
		ST_MAP1,
		ST_MAP2,
		ST_MAP3,
		ST_MAP4,
		ST_IT_SQX,
		ST_IT_SQY,
		ST_IT_XY,
		ST_IT_UPD
	} state_t;

	// Clamp a wide signed sum back into the Q6.26 word range
	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(32'sh7FFF_FFFF);
		lo = -(SUM_W'(33'sh0_8000_0000));
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end else begin
			return v[WORD_W-1:0];
		end
	endfunction

endpackage

[rtl/core/jet_mul.sv]
// Shared signed 32x32 multiplier with a registered 64-bit product.
`timescale 1ns / 1ps

module jet_mul (
	input  logic                            clk,
	input  logic signed [jet_pkg::WORD_W-1:0] op_a,
	input  logic signed [jet_pkg::WORD_W-1:0] op_b,
	output logic signed [jet_pkg::PROD_W-1:0] prod_q
);
	import jet_pkg::*;

	// Register the full-width product
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

[rtl/core/julia_escape_time_core.sv]
// Top level of the Julia escape-time core: sequencer, registers and datapath.
`timescale 1ns / 1ps

// Julia escape-time core. Pulse start while busy is low to hand in one pixel;
// the core maps it to a start point, iterates z = z^2 + c and, when the point
// escapes |z|^2 > 4 or the iteration limit is hit, raises done for exactly one
// cycle with the count, the inside flag and the linear pixel index on result.
// The result is held until the next pixel finishes; sample it in the cycle done
// is high. done rises in the cycle after the last update step, with busy
// already low, so start may be given again in the done cycle. The pace is set
// by the one shared 32x32 multiplier: four products map the coordinates and
// every iteration needs three (zx*zx, zy*zy, zx*zy) plus a step to update z.
// Configuration writes take effect at once and belong in the idle time.
module julia_escape_time_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  jet_pkg::pixel_t                    pixel,
	output logic                               busy,
	input  logic                               cfg_we,
	input  logic [jet_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jet_pkg::WORD_W-1:0]         cfg_wdata,
	output logic                               done,
	output jet_pkg::result_t                   result
);
	import jet_pkg::*;

	// Configuration registers
	logic [COUNT_W-1:0]       max_iter_q;
	logic signed [WORD_W-1:0] c_re_off_q;
	logic signed [WORD_W-1:0] c_im_off_q;
	logic [WORD_W-2:0]        zoom_q;
	logic signed [WORD_W-1:0] center_re_q;
	logic signed [WORD_W-1:0] center_im_q;

	// Sequencer and datapath
	state_t                   state_q;
	state_t                   state_d;
	pixel_t                   pix_q;
	logic [INDEX_W-1:0]       idx_q;
	logic signed [WORD_W-1:0] cre_q;
	logic signed [WORD_W-1:0] cim_q;
	logic signed [WORD_W-1:0] mx_q;
	logic signed [WORD_W-1:0] my_q;
	logic signed [WORD_W-1:0] zx_q;
	logic signed [WORD_W-1:0] zy_q;
	logic signed [PROD_W-1:0] sx_q;
	logic signed [PROD_W-1:0] diff_q;
	logic                     esc_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     done_q;
	result_t                  result_q;

	logic signed [WORD_W-1:0] op_a;
	logic signed [WORD_W-1:0] op_b;
	logic signed [PROD_W-1:0] prod_q;
	logic                     accept;
	logic                     keep_going;
	logic signed [WORD_W-1:0] map_zx;
	logic signed [WORD_W-1:0] map_zy;
	logic signed [WORD_W-1:0] next_zx;
	logic signed [WORD_W-1:0] next_zy;
	logic [PROD_W:0]          mag_sum;
	logic [INDEX_W-1:0]       pix_index;

	jet_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	assign accept     = start && !busy;
	assign keep_going = (count_q < max_iter_q) && !esc_q;

	// Rescale products to Q6.26, add offsets, saturate
	assign map_zx  = sat_word(SUM_W'(prod_q >>> FRAC_BITS) + SUM_W'(center_re_q));
	assign map_zy  = sat_word(SUM_W'(prod_q >>> FRAC_BITS) + SUM_W'(center_im_q));
	assign next_zy = sat_word(SUM_W'(prod_q >>> (FRAC_BITS - 1)) + SUM_W'(cim_q));
	assign next_zx = sat_word(SUM_W'(diff_q >>> FRAC_BITS) + SUM_W'(cre_q));

	// Unrounded magnitude: prod_q holds zy*zy in the compare state
	assign mag_sum = (PROD_W+1)'($unsigned(sx_q)) + (PROD_W+1)'($unsigned(prod_q));

	// Linear pixel position, wrapped to the index width
	assign pix_index = INDEX_W'(pixel.pixel_col)
		+ INDEX_W'(INDEX_W'(pixel.pixel_row) * INDEX_W'(FRAME_WIDTH));

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q  <= MAX_ITER_RST;
			c_re_off_q  <= '0;
			c_im_off_q  <= '0;
			zoom_q      <= ZOOM_RST;
			center_re_q <= '0;
			center_im_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_ITER:  max_iter_q  <= cfg_wdata[COUNT_W-1:0];
				CFG_C_RE_OFF:  c_re_off_q  <= signed'(cfg_wdata);
				CFG_C_IM_OFF:  c_im_off_q  <= signed'(cfg_wdata);
				CFG_ZOOM:      zoom_q      <= cfg_wdata[WORD_W-2:0];
				CFG_CENTER_RE: center_re_q <= signed'(cfg_wdata);
				CFG_CENTER_IM: center_im_q <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_MAP0;
			ST_MAP0:   state_d = ST_MAP1;
			ST_MAP1:   state_d = ST_MAP2;
			ST_MAP2:   state_d = ST_MAP3;
			ST_MAP3:   state_d = ST_MAP4;
			ST_MAP4:   state_d = ST_IT_SQX;
			ST_IT_SQX: state_d = ST_IT_SQY;
			ST_IT_SQY: state_d = ST_IT_XY;
			ST_IT_XY:  state_d = ST_IT_UPD;
			ST_IT_UPD: state_d = keep_going ? ST_IT_SQX : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Select multiplier operands per step
	always_comb begin
		busy = (state_q != ST_IDLE);
		op_a = zx_q;
		op_b = zy_q;
		unique case (state_q)
			ST_MAP0: begin
				op_a = signed'(WORD_W'(pix_q.pixel_col));
				op_b = K_STEP;
			end
			ST_MAP1: begin
				op_a = signed'(WORD_W'(pix_q.pixel_row));
				op_b = K_STEP;
			end
			ST_MAP2: begin
				op_a = mx_q;
				op_b = signed'({1'b0, zoom_q});
			end
			ST_MAP3: begin
				op_a = my_q;
				op_b = signed'({1'b0, zoom_q});
			end
			ST_IT_SQX: begin
				op_a = zx_q;
				op_b = zx_q;
			end
			ST_IT_SQY: begin
				op_a = zy_q;
				op_b = zy_q;
			end
			default: begin
				op_a = zx_q;
				op_b = zy_q;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_IT_UPD) && !keep_going;
			if (accept) begin
				count_q <= '0;
			end else if ((state_q == ST_IT_UPD) && keep_going) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					pix_q <= pixel;
					idx_q <= pix_index;
					cre_q <= sat_word(SUM_W'(K_CRE) + SUM_W'(c_re_off_q));
					cim_q <= sat_word(SUM_W'(K_CIM) + SUM_W'(c_im_off_q));
				end
			end
			ST_MAP1: mx_q <= prod_q[WORD_W-1:0] - K_XOFS;
			ST_MAP2: my_q <= prod_q[WORD_W-1:0] - K_YOFS;
			ST_MAP3: zx_q <= map_zx;
			ST_MAP4: zy_q <= map_zy;
			ST_IT_SQY: sx_q <= prod_q;
			ST_IT_XY: begin
				esc_q  <= (mag_sum > ESCAPE_LIMIT);
				diff_q <= sx_q - prod_q;
			end
			ST_IT_UPD: begin
				if (keep_going) begin
					zx_q <= next_zx;
					zy_q <= next_zy;
				end else begin
					result_q.iteration_count <= count_q;
					result_q.inside_set      <= (count_q == max_iter_q);
					result_q.pixel_index     <= idx_q;
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	// A result only follows the final update step
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_IT_UPD))
		else $error("done without a finishing update step");

	// The inside flag matches the count against the limit
	a_inside_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.inside_set == (result.iteration_count == max_iter_q)))
		else $error("inside_set disagrees with iteration_count");

	// The count never passes the limit while a pixel is in work
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (count_q <= max_iter_q))
		else $error("iteration count beyond the limit");

	// An accepted transaction starts the coordinate mapping
	a_accept_maps: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_MAP0))
		else $error("accepted transaction did not start mapping");

endmodule
